>>> design/mvt_pkg.sv
`timescale 1ns / 1ps

package mvt_pkg;

  // field widths
  localparam int unsigned COMP_W    = 32;
  localparam int unsigned PROD_W    = 2 * COMP_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned SHIFT_W   = SUM_W - FRAC_W;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned N_CFG     = 8;
  localparam int unsigned DIM       = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL0_ROWS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL3_ROWS23 = 4'd7;

  // identity matrix after reset
  localparam logic [CFG_W-1:0] CFG_RESET [N_CFG] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  localparam logic signed [COMP_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COMP_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
    logic signed [COMP_W-1:0] vec_w;
  } vec_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic                     saturated;
  } res_t;

endpackage

>>> design/mvt_ifs.sv
`timescale 1ns / 1ps

interface mvt_in_if import mvt_pkg::*; ();
  logic valid;
  logic ready;
  vec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvt_out_if import mvt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvt_cfg_if import mvt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

>>> design/matrix4x4_vector_transform.sv
`timescale 1ns / 1ps
// result path: input beat to result beat through four registered stages (multiply, pair add, row add, saturate)
// throughput: one vector per cycle while out_bus.ready holds; each of the four stages holds one beat
// a stage stalls only when it and every stage after it are full
// reset (synchronous, rst_n low): pipeline empties, matrix returns to identity
// configuration writes are taken every cycle and are meant only while the pipeline is empty

module matrix4x4_vector_transform import mvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mvt_in_if.sink     in_bus,
  mvt_out_if.source  out_bus,
  mvt_cfg_if.sink    cfg_bus
);

  logic [CFG_W-1:0] cfg_r [N_CFG];

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [PROD_W-1:0]  prod_r [DIM][DIM];
  logic signed [PROD_W-1:0]  prod_nxt [DIM][DIM];
  logic signed [PAIR_W-1:0]  pair_r [DIM][2];
  logic signed [PAIR_W-1:0]  pair_nxt [DIM][2];
  logic signed [SUM_W-1:0]   sum_r [DIM];
  logic signed [SUM_W-1:0]   sum_nxt [DIM];
  logic signed [COMP_W-1:0]  comp_nxt [DIM];
  logic [DIM-1:0]            clip_nxt;
  res_t                      res_r;

  // configuration registers, out-of-range indexes dropped
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_bus.valid && cfg_bus.idx <= REG_COL3_ROWS23) begin
      cfg_r[cfg_bus.idx[2:0]] <= cfg_bus.data;
    end
  end

  // stage ready chain: a stage loads when empty or when the next one moves
  assign rdy4 = !v4_r || out_bus.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_bus.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_bus.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: sixteen 32x32 signed products
  always_comb begin
    logic [CFG_W-1:0]         cfg_w;
    logic signed [COMP_W-1:0] ent;
    logic signed [COMP_W-1:0] vin [DIM];
    vin[0] = in_bus.data.vec_x;
    vin[1] = in_bus.data.vec_y;
    vin[2] = in_bus.data.vec_z;
    vin[3] = in_bus.data.vec_w;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        cfg_w = cfg_r[3'(2 * c + (r >> 1))];
        ent = r[0] ? cfg_w[63:32] : cfg_w[31:0];
        prod_nxt[r][c] = PROD_W'(ent) * PROD_W'(vin[c]);
      end
    end
  end

  // stage 2: pairwise sums per row
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      pair_nxt[r][0] = PAIR_W'(prod_r[r][0]) + PAIR_W'(prod_r[r][1]);
      pair_nxt[r][1] = PAIR_W'(prod_r[r][2]) + PAIR_W'(prod_r[r][3]);
    end
  end

  // stage 3: row sums, exact
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      sum_nxt[r] = SUM_W'(pair_r[r][0]) + SUM_W'(pair_r[r][1]);
    end
  end

  // stage 4: floor shift by 16 and clip to 32 bits
  always_comb begin
    logic [SHIFT_W-1:0] sh;
    for (int r = 0; r < DIM; r++) begin
      sh = sum_r[r][SUM_W-1:FRAC_W];
      clip_nxt[r] = (sh[SHIFT_W-1:COMP_W-1] != '0) && (sh[SHIFT_W-1:COMP_W-1] != '1);
      if (!clip_nxt[r]) begin
        comp_nxt[r] = sh[COMP_W-1:0];
      end else if (sh[SHIFT_W-1]) begin
        comp_nxt[r] = SAT_MIN;
      end else begin
        comp_nxt[r] = SAT_MAX;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) prod_r <= prod_nxt;
    if (rdy2) pair_r <= pair_nxt;
    if (rdy3) sum_r <= sum_nxt;
    if (rdy4) begin
      res_r.out_x     <= comp_nxt[0];
      res_r.out_y     <= comp_nxt[1];
      res_r.out_z     <= comp_nxt[2];
      res_r.out_w     <= comp_nxt[3];
      res_r.saturated <= |clip_nxt;
    end
  end

  assign out_bus.valid = v4_r;
  assign out_bus.data  = res_r;

`ifndef SYNTHESIS
  // a held stage keeps its products while the pair stage is blocked
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(prod_r[0][0]) && $stable(prod_r[3][3])))
    else $error("stage 1 lost or changed a stalled beat");

  // a new result beat comes only from a full row-sum stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v4_r) |-> $past(v3_r))
    else $error("result valid without a row-sum beat");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r && !v4_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> test/mvt_transform_checker.sv
`timescale 1ns / 1ps

module mvt_transform_checker import mvt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mvt_in_if    in_bus,
  mvt_out_if   out_bus,
  mvt_cfg_if   cfg_bus,
  output int   fail_count,
  output int   pending_count
);

  localparam logic [COMP_W-1:0] Q16_ONE    = 32'h0001_0000;
  localparam int                REPORT_MAX = 10;

  // own copy of the matrix, column major, two entries per word
  logic [CFG_W-1:0] matrix_regs [N_CFG];
  res_t             xformed_q [$];

  // matrix times vector, exact sum of products, floor shift, saturate
  function automatic res_t transform_vec(input vec_t v);
    logic signed [COMP_W-1:0] comp    [DIM];
    logic signed [COMP_W-1:0] row_out [DIM];
    logic signed [COMP_W-1:0] entry_val;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  acc_sh;
    logic signed [SUM_W-1:0]  ext_m;
    logic signed [SUM_W-1:0]  ext_v;
    logic [CFG_W-1:0]         word;
    logic                     sat;
    res_t                     r;
    comp[0] = v.vec_x;
    comp[1] = v.vec_y;
    comp[2] = v.vec_z;
    comp[3] = v.vec_w;
    sat = 1'b0;
    for (int row = 0; row < DIM; row++) begin
      acc = '0;
      for (int col = 0; col < DIM; col++) begin
        word = matrix_regs[col * 2 + row / 2];
        entry_val = (row % 2) ? word[63:32] : word[31:0];
        ext_m = entry_val;
        ext_v = comp[col];
        acc = acc + ext_m * ext_v;
      end
      // arithmetic shift rounds toward minus infinity
      acc_sh = acc >>> FRAC_W;
      if (acc_sh > SAT_MAX) begin
        row_out[row] = SAT_MAX;
        sat = 1'b1;
      end else if (acc_sh < SAT_MIN) begin
        row_out[row] = SAT_MIN;
        sat = 1'b1;
      end else begin
        row_out[row] = acc_sh[COMP_W-1:0];
      end
    end
    r.out_x     = row_out[0];
    r.out_y     = row_out[1];
    r.out_z     = row_out[2];
    r.out_w     = row_out[3];
    r.saturated = sat;
    return r;
  endfunction

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    res_t exp_r;
    res_t got_r;
    if (!rst_n) begin
      // identity matrix after reset
      for (int i = 0; i < N_CFG; i++) matrix_regs[i] = '0;
      for (int d = 0; d < DIM; d++) begin
        if (d % 2) matrix_regs[d * 2 + d / 2][63:32] = Q16_ONE;
        else       matrix_regs[d * 2 + d / 2][31:0]  = Q16_ONE;
      end
      xformed_q.delete();
      fail_count = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_bus.valid && out_bus.ready) begin
        got_r = out_bus.data;
        if (xformed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result beat with nothing expected: x=%h y=%h z=%h w=%h sat=%b",
                     $realtime, got_r.out_x, got_r.out_y, got_r.out_z, got_r.out_w,
                     got_r.saturated);
        end else begin
          exp_r = xformed_q.pop_front();
          if (got_r.out_x !== exp_r.out_x || got_r.out_y !== exp_r.out_y ||
              got_r.out_z !== exp_r.out_z || got_r.out_w !== exp_r.out_w ||
              got_r.saturated !== exp_r.saturated) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: mismatch exp x=%h y=%h z=%h w=%h sat=%b got x=%h y=%h z=%h w=%h sat=%b",
                       $realtime, exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.out_w,
                       exp_r.saturated, got_r.out_x, got_r.out_y, got_r.out_z,
                       got_r.out_w, got_r.saturated);
          end
        end
      end
      // vector beat: predict with the matrix as it stands
      if (in_bus.valid && in_bus.ready)
        xformed_q.push_back(transform_vec(in_bus.data));
      // register write, indexes past the last register are dropped
      if (cfg_bus.valid && cfg_bus.ready && cfg_bus.idx <= REG_COL3_ROWS23)
        matrix_regs[cfg_bus.idx[2:0]] = cfg_bus.data;
    end
    pending_count = xformed_q.size();
  end

endmodule

>>> test/matrix4x4_vector_transform_tb.sv
`timescale 1ns / 1ps

module matrix4x4_vector_transform_tb;
  import mvt_pkg::*;

  localparam int                WATCHDOG_LIMIT  = 1000;
  localparam int                DRAIN_CYCLES    = 8;
  localparam int                N_PHASES        = 10;
  localparam int                ITEMS_PER_PHASE = 100;
  localparam logic [COMP_W-1:0] Q_ONE           = 32'h0001_0000;
  localparam logic [COMP_W-1:0] Q_NEG_ONE       = 32'hFFFF_0000;
  localparam logic [COMP_W-1:0] LSB_NEG         = 32'hFFFF_FFFF;

  typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_EDGE, SPREAD_ANY} spread_t;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   fail_count;
  int   pending_count;
  int   stall_cycles;

  mvt_in_if  in_bus ();
  mvt_out_if out_bus ();
  mvt_cfg_if cfg_bus ();

  matrix4x4_vector_transform u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  mvt_transform_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_bus        (in_bus),
    .out_bus       (out_bus),
    .cfg_bus       (cfg_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog: cycles in a row with no beat on any channel
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // one component, spread over the full range, a small range or edge values
  function automatic logic [COMP_W-1:0] pick_comp(input spread_t kind, input int unsigned mag);
    spread_t k;
    int      small_val;
    k = kind;
    if (k == SPREAD_ANY) k = spread_t'($urandom_range(SPREAD_EDGE));
    small_val = int'($urandom_range(0, 2 * (1 << mag))) - (1 << mag);
    case (k)
      SPREAD_FULL:  return $urandom;
      SPREAD_SMALL: return small_val;
      default: begin
        case ($urandom_range(5))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          3:       return 32'h1;
          4:       return Q_ONE;
          default: return Q_NEG_ONE;
        endcase
      end
    endcase
  endfunction

  // one vector beat, with random gaps before it
  task automatic push_vec(input vec_t v);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= v;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // one register write beat
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // same entry everywhere in the matrix
  task automatic fill_matrix(input logic [COMP_W-1:0] e);
    for (int i = 0; i < N_CFG; i++) write_reg(REG_COL0_ROWS01 + i, {e, e});
  endtask

  // stop sending and let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    spread_t     mk;
    spread_t     vk;
    int unsigned roll;
    rst_n         = 1'b0;
    in_idle_pct   = 36;
    out_idle_pct  = 51;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.idx   = '0;
    cfg_bus.data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity after reset, w passes through the bottom row
    push_vec({32'h0, 32'h0, 32'h0, 32'h0});
    push_vec({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX});
    push_vec({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
    push_vec({SAT_MAX, SAT_MIN, LSB_NEG, 32'h1});
    push_vec({Q_ONE, Q_NEG_ONE, 32'h1234_5678, 32'h1});
    settle();

    // most negative entries: largest positive sum, negative overflow, exact min
    fill_matrix(SAT_MIN);
    push_vec({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
    push_vec({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX});
    push_vec({32'h1, 32'h0, 32'h0, 32'h0});
    push_vec({LSB_NEG, 32'h0, 32'h0, 32'h0});
    push_vec({Q_ONE, 32'h0, 32'h0, 32'h0});
    push_vec({Q_ONE, Q_ONE, 32'h0, 32'h0});
    settle();

    // smallest entry: negative sums round toward minus infinity
    fill_matrix(32'h1);
    push_vec({LSB_NEG, 32'h0, 32'h0, 32'h0});
    push_vec({32'h1, 32'h0, 32'h0, 32'h0});
    push_vec({32'h0000_FFFF, 32'h1, 32'h0, 32'h0});
    push_vec({Q_NEG_ONE, 32'h0, 32'h0, 32'h0});
    settle();

    // largest entries: exact max, then overflow both ways
    fill_matrix(SAT_MAX);
    push_vec({Q_ONE, 32'h0, 32'h0, 32'h0});
    push_vec({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX});
    push_vec({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
    settle();

    // writes past the last register must leave the matrix alone
    for (int i = REG_COL3_ROWS23 + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i, {$urandom, $urandom});
    push_vec({Q_ONE, Q_ONE, 32'h0, 32'h0});
    push_vec({Q_ONE, 32'h0, 32'h0, 32'h0});
    settle();

    // random phases, a fresh matrix each time
    for (int p = 0; p < N_PHASES; p++) begin
      @(posedge clk);
      if (p < 4) begin
        in_idle_pct  = 36;
        out_idle_pct = 51;
      end else if (p < 7) begin
        in_idle_pct  = 51;
        out_idle_pct = 36;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      mk = spread_t'($urandom_range(SPREAD_ANY));
      for (int i = 0; i < N_CFG; i++)
        write_reg(REG_COL0_ROWS01 + i, {pick_comp(mk, 18), pick_comp(mk, 18)});
      if ($urandom_range(1))
        write_reg(REG_COL3_ROWS23 + 1 + $urandom_range(REG_COL3_ROWS23), {$urandom, $urandom});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 55)      vk = SPREAD_SMALL;
        else if (roll < 75) vk = SPREAD_ANY;
        else if (roll < 90) vk = SPREAD_FULL;
        else                vk = SPREAD_EDGE;
        push_vec({pick_comp(vk, 24), pick_comp(vk, 24), pick_comp(vk, 24),
                  pick_comp(vk, 24)});
      end
      settle();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
